// File: rtl/fgpr_pkg.sv
// Shared types, widths and constants of the fuzzy gain PID controller with relay.
package fgpr_pkg;

    // Default number of fraction bits of temperatures, gains and drive
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths
    localparam int TEMP_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int BAND_W     = 14;
    localparam int DRIVE_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Gain factor in Q2.8
    localparam int FACTOR_BITS = 8;
    localparam int FAC_W       = 10;
    localparam int FAC_HIGH    = 461;
    localparam int FAC_MID     = 307;
    localparam int FAC_LOW     = 154;
    localparam int FAC_RATE    = 333;
    localparam int FAC_HALF    = 1 << (FACTOR_BITS - 1);
    localparam int FAC_HIGH_FAST = (FAC_HIGH * FAC_RATE + FAC_HALF) >> FACTOR_BITS;
    localparam int FAC_MID_FAST  = (FAC_MID * FAC_RATE + FAC_HALF) >> FACTOR_BITS;
    localparam int FAC_LOW_FAST  = (FAC_LOW * FAC_RATE + FAC_HALF) >> FACTOR_BITS;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] SETPOINT_RST   = 16'sd6400;
    localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = 16'd768;
    localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST = 16'd205;
    localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = 16'd512;
    localparam logic [BAND_W-1:0]        BAND_RST       = 14'd1280;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_DERIV_GAIN = 3'd3,
        REG_HYST_BAND  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] setpoint;
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [GAIN_W-1:0]        deriv_gain;
        logic [BAND_W-1:0]        hyst_band;
    } cfg_regs_t;

    // Datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR,
        OP_FAC,
        OP_MUL_PE,
        OP_MUL_DR,
        OP_MUL_P,
        OP_MUL_D,
        OP_RND_D,
        OP_DRIVE
    } dp_op_t;

    typedef struct packed {
        logic   capture;
        dp_op_t op;
        logic   commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_op;
    } dp_status_t;

endpackage

// File: rtl/fgpr_cfg.sv
// Configuration register file of the fuzzy gain PID controller.
module fgpr_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fgpr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fgpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output fgpr_pkg::cfg_regs_t              cfg
);
    import fgpr_pkg::*;

    cfg_regs_t cfg_reg;

    // Always take a configuration word
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Write the addressed register, drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint   <= SETPOINT_RST;
            cfg_reg.prop_gain  <= PROP_GAIN_RST;
            cfg_reg.integ_gain <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain <= DERIV_GAIN_RST;
            cfg_reg.hyst_band  <= BAND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SETPOINT:   cfg_reg.setpoint   <= $signed(cfg_data[TEMP_W-1:0]);
                REG_PROP_GAIN:  cfg_reg.prop_gain  <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN: cfg_reg.integ_gain <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN: cfg_reg.deriv_gain <= cfg_data[GAIN_W-1:0];
                REG_HYST_BAND:  cfg_reg.hyst_band  <= cfg_data[BAND_W-1:0];
                default:        ;
            endcase
        end
    end

endmodule

// File: rtl/fgpr_ctrl.sv
// Sequencing controller of the fuzzy gain PID controller.
module fgpr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output fgpr_pkg::dp_cmd_t    cmd,
    input  fgpr_pkg::dp_status_t status
);
    import fgpr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_FAC,
        S_PE,
        S_DR,
        S_P,
        S_D,
        S_RND,
        S_DRIVE,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Load the output word when the slot is free or being emptied
    assign commit = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // Step through the multiply schedule
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_ERR;
            S_ERR:   state_next = status.clear_op ? S_OUT : S_FAC;
            S_FAC:   state_next = S_PE;
            S_PE:    state_next = S_DR;
            S_DR:    state_next = S_P;
            S_P:     state_next = S_D;
            S_D:     state_next = S_RND;
            S_RND:   state_next = S_DRIVE;
            S_DRIVE: state_next = S_OUT;
            S_OUT:   if (commit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the output word valid until it is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Decode datapath commands
    always_comb
    begin
        cmd.capture = in_valid && in_ready;
        cmd.commit  = commit;
        case (state_reg)
            S_ERR:   cmd.op = OP_ERR;
            S_FAC:   cmd.op = OP_FAC;
            S_PE:    cmd.op = OP_MUL_PE;
            S_DR:    cmd.op = OP_MUL_DR;
            S_P:     cmd.op = OP_MUL_P;
            S_D:     cmd.op = OP_MUL_D;
            S_RND:   cmd.op = OP_RND_D;
            S_DRIVE: cmd.op = OP_DRIVE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("controller took a word while busy");

    a_commit_shows_word: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (out_valid_reg && in_ready))
        else $error("committed word not shown or controller not idle");
`endif

endmodule

// File: rtl/fgpr_dp.sv
// Datapath of the fuzzy gain PID controller: error, factor, shared multiplier, relay.
module fgpr_dp #(
    parameter int FRAC_BITS = fgpr_pkg::FRACTION_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fgpr_pkg::dp_cmd_t                 cmd,
    output fgpr_pkg::dp_status_t              status,
    input  fgpr_pkg::cfg_regs_t               cfg,
    input  logic                              opcode,
    input  logic signed [fgpr_pkg::TEMP_W-1:0] measured_temp,
    output logic [fgpr_pkg::DRIVE_W-1:0]      drive_level,
    output logic                              relay_on
);
    import fgpr_pkg::*;

    localparam int ERR_W  = TEMP_W + 1;
    localparam int RATE_W = TEMP_W + 2;
    localparam int PE_W   = ERR_W + FAC_W + 1;
    localparam int DR_W   = RATE_W + FAC_W + 1;
    localparam int MA_W   = DR_W;
    localparam int MB_W   = GAIN_W + 1;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int ACC_W  = FRAC_BITS + 7;
    localparam int P_SH   = FRAC_BITS + FACTOR_BITS;

    localparam logic signed [SUM_W-1:0] ONE    = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] THREE  = SUM_W'(3) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] FULL   = SUM_W'(100) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] MID    = SUM_W'(50) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF_I = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] HALF_P = SUM_W'(1) << (P_SH - 1);

    logic                      opcode_reg;
    logic signed [TEMP_W-1:0]  temp_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic [FAC_W-1:0]          fac_reg;
    logic signed [PE_W-1:0]    pe_reg;
    logic signed [DR_W-1:0]    dr_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SUM_W-1:0]   p_reg;
    logic signed [SUM_W-1:0]   d_reg;
    logic [ACC_W-1:0]          drive_reg;
    logic [ACC_W-1:0]          integ_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic                      relay_reg;
    logic [DRIVE_W-1:0]        drive_out_reg;
    logic                      relay_out_reg;

    logic signed [ERR_W-1:0]   err_calc;
    logic signed [RATE_W-1:0]  rate_calc;
    logic [ERR_W-1:0]          abs_err;
    logic [RATE_W-1:0]         rate_mag;
    logic                      err_high;
    logic                      err_mid;
    logic                      rate_fast;
    logic [FAC_W-1:0]          fac_sel;
    logic signed [MA_W-1:0]    mul_a;
    logic signed [MB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SUM_W-1:0]   prod_ext;
    logic signed [SUM_W-1:0]   rnd_i;
    logic signed [SUM_W-1:0]   rnd_p;
    logic signed [SUM_W-1:0]   integ_ext;
    logic signed [SUM_W-1:0]   integ_sum;
    logic [ACC_W-1:0]          integ_next;
    logic signed [SUM_W-1:0]   drive_sum;
    logic [ACC_W-1:0]          drive_next;
    logic signed [SUM_W-1:0]   drive_ext;
    logic signed [SUM_W-1:0]   relay_hi;
    logic signed [SUM_W-1:0]   relay_lo;
    logic                      relay_next;

    assign status.clear_op = opcode_reg;
    assign drive_level     = drive_out_reg;
    assign relay_on        = relay_out_reg;

    // Error and its change since the last sample
    assign err_calc  = ERR_W'(cfg.setpoint) - ERR_W'(temp_reg);
    assign rate_calc = RATE_W'(err_calc) - RATE_W'(last_err_reg);

    // Pick the gain factor from the error size and rate
    assign abs_err   = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign rate_mag  = rate_reg[RATE_W-1] ? RATE_W'(-rate_reg) : RATE_W'(rate_reg);
    assign err_high  = $signed(SUM_W'(abs_err)) > THREE;
    assign err_mid   = $signed(SUM_W'(abs_err)) > ONE;
    assign rate_fast = $signed(SUM_W'({rate_mag, 1'b0})) > THREE;

    always_comb
    begin
        if (err_high)
            fac_sel = rate_fast ? FAC_W'(FAC_HIGH_FAST) : FAC_W'(FAC_HIGH);
        else if (err_mid)
            fac_sel = rate_fast ? FAC_W'(FAC_MID_FAST) : FAC_W'(FAC_MID);
        else
            fac_sel = rate_fast ? FAC_W'(FAC_LOW_FAST) : FAC_W'(FAC_LOW);
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        case (cmd.op)
            OP_FAC:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = $signed({1'b0, cfg.integ_gain});
            end
            OP_MUL_PE:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'($signed({1'b0, fac_reg}));
            end
            OP_MUL_DR:
            begin
                mul_a = MA_W'(rate_reg);
                mul_b = MB_W'($signed({1'b0, fac_reg}));
            end
            OP_MUL_P:
            begin
                mul_a = MA_W'(pe_reg);
                mul_b = $signed({1'b0, cfg.prop_gain});
            end
            OP_MUL_D:
            begin
                mul_a = MA_W'(dr_reg);
                mul_b = $signed({1'b0, cfg.deriv_gain});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round registered products half up
    assign prod_ext = SUM_W'(prod_reg);
    assign rnd_i    = (prod_ext + HALF_I) >>> FRAC_BITS;
    assign rnd_p    = (prod_ext + HALF_P) >>> P_SH;

    // Add to the integral and clamp to 0..100
    assign integ_ext = $signed({{(SUM_W - ACC_W){1'b0}}, integ_reg});
    assign integ_sum = integ_ext + rnd_i;

    always_comb
    begin
        if (integ_sum < 0)
            integ_next = '0;
        else if (integ_sum > FULL)
            integ_next = ACC_W'(FULL);
        else
            integ_next = ACC_W'(integ_sum);
    end

    // Sum P, I and D and clamp to 0..100
    assign drive_sum = p_reg + integ_ext + d_reg;

    always_comb
    begin
        if (drive_sum < 0)
            drive_next = '0;
        else if (drive_sum > FULL)
            drive_next = ACC_W'(FULL);
        else
            drive_next = ACC_W'(drive_sum);
    end

    // Relay with hysteresis around the midpoint
    assign drive_ext = $signed({{(SUM_W - ACC_W){1'b0}}, drive_reg});
    assign relay_hi  = MID + $signed({{(SUM_W - BAND_W){1'b0}}, cfg.hyst_band});
    assign relay_lo  = MID - $signed({{(SUM_W - BAND_W){1'b0}}, cfg.hyst_band});

    always_comb
    begin
        if (!relay_reg)
            relay_next = drive_ext > relay_hi;
        else
            relay_next = !(drive_ext < relay_lo);
    end

    // Payload registers of the schedule
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            opcode_reg <= opcode;
            temp_reg   <= measured_temp;
        end
        if (cmd.op == OP_ERR)
        begin
            err_reg  <= err_calc;
            rate_reg <= rate_calc;
        end
        if (cmd.op == OP_FAC)
            fac_reg <= fac_sel;
        prod_reg <= mul_p;
        if (cmd.op == OP_MUL_DR)
            pe_reg <= PE_W'(prod_reg);
        if (cmd.op == OP_MUL_P)
            dr_reg <= DR_W'(prod_reg);
        if (cmd.op == OP_MUL_D)
            p_reg <= rnd_p;
        if (cmd.op == OP_RND_D)
            d_reg <= rnd_p;
        if (cmd.op == OP_DRIVE)
            drive_reg <= drive_next;
    end

    // Controller state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            last_err_reg  <= '0;
            relay_reg     <= 1'b0;
            drive_out_reg <= '0;
            relay_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_MUL_PE)
                integ_reg <= integ_next;
            if (cmd.commit)
            begin
                if (opcode_reg)
                begin
                    integ_reg     <= '0;
                    last_err_reg  <= '0;
                    relay_reg     <= 1'b0;
                    drive_out_reg <= '0;
                    relay_out_reg <= 1'b0;
                end
                else
                begin
                    last_err_reg  <= err_reg;
                    relay_reg     <= relay_next;
                    drive_out_reg <= DRIVE_W'(drive_ext);
                    relay_out_reg <= relay_next;
                end
            end
        end
    end

`ifndef SYNTH
    a_integ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        $signed({{(SUM_W - ACC_W){1'b0}}, integ_reg}) <= FULL)
        else $error("integral above full scale");

    a_clear_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && opcode_reg) |=> (drive_level == '0 && !relay_on && !relay_reg))
        else $error("clear word did not zero the output");
`endif

endmodule

// File: rtl/fuzzy_gain_pid_with_relay_top.sv
// Top level of the fuzzy gain PID temperature controller with hysteresis relay.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word: opcode and measured_temp.
//   Opcode 0 runs one control step on the sample; opcode 1 clears the last
//   error, the integral and the relay, and returns drive 0 and relay off.
//   Output channel (out_valid/out_ready) returns one word per input word:
//   drive_level (0..100.0, saturated) and relay_on.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   setpoint, the three gains and the relay half band; it is always ready.
//   The user must write it only while the block is idle; the block does not
//   enforce this. A sample step goes from acceptance to the output word
//   through five products that run one after another through a single shared
//   multiplier plus the rounding, sum and relay steps. A clear word goes
//   straight from the error step to the output step. A new word is accepted in
//   the cycle after the previous result is loaded, one word at a time.
//   The output register holds a finished word while the receiver stalls; the
//   next input word is still accepted and worked on, and waits only at the
//   final step for the slot to free.
//   Reset loads the register defaults and clears error, integral and relay.
module fuzzy_gain_pid_with_relay_top #(
    parameter int FRAC_BITS = fgpr_pkg::FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic signed [fgpr_pkg::TEMP_W-1:0] measured_temp,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [fgpr_pkg::DRIVE_W-1:0]       drive_level,
    output logic                               relay_on,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fgpr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fgpr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fgpr_pkg::*;

    cfg_regs_t  cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    fgpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fgpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    fgpr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg           (cfg),
        .opcode        (opcode),
        .measured_temp (measured_temp),
        .drive_level   (drive_level),
        .relay_on      (relay_on)
    );

endmodule
